// ===== hw/rtl/pfd_pkg.sv =====
package pfd_pkg;

  localparam logic [1:0] ReqAdd  = 2'd0;
  localparam logic [1:0] ReqFwd  = 2'd1;
  localparam logic [1:0] ReqCnt  = 2'd2;
  localparam logic [1:0] ReqNone = 2'd3;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_FWD,
    KIND_CNT,
    KIND_NONE
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] src_id;
    logic [15:0] dst_id;
    logic [31:0] arrival_time;
    logic [31:0] range_start;
    logic [31:0] range_end;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic        packet_valid;
    logic [15:0] out_src;
    logic [15:0] out_dst;
    logic [31:0] out_time;
    logic [6:0]  match_count;
  } out_word_t;

  typedef struct packed {
    kind_e    kind;
    in_word_t word;
  } item_t;

endpackage

// ===== hw/rtl/pfd_front.sv =====
module pfd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pfd_pkg::in_word_t in_word_i,
  output logic             item_valid_o,
  output pfd_pkg::item_t   item_o,
  input  logic             item_pop_i
);
  import pfd_pkg::*;

  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item_new;

  always_comb begin
    item_new.word = in_word_i;
    unique case (in_word_i.req_type)
      ReqAdd:  item_new.kind = KIND_ADD;
      ReqFwd:  item_new.kind = KIND_FWD;
      ReqCnt:  item_new.kind = KIND_CNT;
      default: item_new.kind = KIND_NONE;
    endcase
  end

  assign in_stall_o   = cnt_q[1];
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = slot_q[rd_q];
  assign push         = in_valid_i && !cnt_q[1];
  assign pop          = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/pfd_back.sv =====
module pfd_back #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  pfd_pkg::item_t     item_i,
  output logic               item_pop_o,
  input  logic [6:0]         limit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pfd_pkg::out_word_t out_word_o
);
  import pfd_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int LimW = (CW > 7) ? CW : 7;
  localparam logic [AW:0]     CapA = (AW + 1)'(CAPACITY);
  localparam logic [LimW-1:0] CapL = LimW'(CAPACITY);

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= CapA) ? s - CapA : s;
    return r[AW-1:0];
  endfunction

  logic [63:0] mem [CAPACITY];

  state_e      state_q, state_d;
  item_t       cur_q;
  logic [AW-1:0] head_q;
  logic [CW-1:0] occ_q, idx_q, n_q, n_new;
  logic        cmp_v_q, dup_q;
  logic [6:0]  cnt_q;
  logic [63:0] rd_q, fwd_q, key;
  logic        outv_q;
  out_word_t   outw_q, res;
  logic        take, rd_en, done, drop, do_wr;
  logic [LimW-1:0] lim, eff;
  logic [AW-1:0] rd_addr, wr_addr, head_inc;

  assign key = {cur_q.word.src_id, cur_q.word.dst_id, cur_q.word.arrival_time};
  assign rd_addr  = wrap({1'b0, head_q} + (AW + 1)'(idx_q));
  assign wr_addr  = wrap({1'b0, head_q} + (AW + 1)'(occ_q));
  assign head_inc = wrap({1'b0, head_q} + (AW + 1)'(1));

  always_comb begin
    lim = LimW'(limit_i);
    if (lim == '0) eff = LimW'(1);
    else if (lim > CapL) eff = CapL;
    else eff = lim;
  end
  assign drop = LimW'(occ_q) >= eff;

  always_comb begin
    unique case (item_i.kind)
      KIND_ADD, KIND_CNT: n_new = occ_q;
      KIND_FWD:           n_new = (occ_q != '0) ? CW'(1) : '0;
      default:            n_new = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = ST_SCAN;
      ST_SCAN: if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    take  = 1'b0;
    rd_en = 1'b0;
    done  = 1'b0;
    unique case (state_q)
      ST_IDLE: take = item_valid_i && (!outv_q || !out_stall_i);
      ST_SCAN: begin
        rd_en = idx_q < n_q;
        done  = !rd_en && !cmp_v_q;
      end
      default: ;
    endcase
    do_wr = done && cur_q.kind == KIND_ADD && !dup_q;
  end

  always_comb begin
    res = '0;
    unique case (cur_q.kind)
      KIND_ADD: res.accepted = !dup_q;
      KIND_FWD: begin
        res.packet_valid = n_q != '0;
        if (n_q != '0) begin
          res.out_src  = fwd_q[63:48];
          res.out_dst  = fwd_q[47:32];
          res.out_time = fwd_q[31:0];
        end
      end
      KIND_CNT: res.match_count = cnt_q;
      default: ;
    endcase
  end

  assign item_pop_o  = take;
  assign out_valid_o = outv_q;
  assign out_word_o  = outw_q;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem[wr_addr] <= key;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= item_i;
      n_q   <= n_new;
      idx_q <= '0;
      dup_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (rd_en) idx_q <= idx_q + CW'(1);
      if (cmp_v_q) begin
        fwd_q <= rd_q;
        if (rd_q == key) dup_q <= 1'b1;
        if (rd_q[47:32] == cur_q.word.dst_id && rd_q[31:0] >= cur_q.word.range_start
            && rd_q[31:0] <= cur_q.word.range_end && cnt_q != 7'h7f) begin
          cnt_q <= cnt_q + 7'd1;
        end
      end
    end
    if (done) outw_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      occ_q   <= '0;
      cmp_v_q <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cmp_v_q <= rd_en;
      if (done) outv_q <= 1'b1;
      else if (outv_q && !out_stall_i) outv_q <= 1'b0;
      if (do_wr) begin
        if (drop) head_q <= head_inc;
        else occ_q <= occ_q + CW'(1);
      end else if (done && cur_q.kind == KIND_FWD && n_q != '0) begin
        head_q <= head_inc;
        occ_q  <= occ_q - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/packet_fifo_dedup_range_count.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_word_i
// out       output     out_valid_o / out_stall_i  out_word_o
// cfg       input      cfg_we_i                   cfg_data_i
// The back end reads every stored entry for an add or count word, one entry for a forward
// from a nonempty queue and none for any word with nothing to read, through the single read
// port of the entry memory, which is swept one entry per cycle.
// A two-word queue accepts input while the back end scans or the output word is stalled.
// Reset empties the queue and sets the limit to 64; the entry memory is not cleared.
module packet_fifo_dedup_range_count #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pfd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pfd_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i
);
  import pfd_pkg::*;

  logic [6:0] limit_q;
  item_t      item;
  logic       item_valid, item_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 7'd64;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  pfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  pfd_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .limit_i      (limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule

// ===== test/packet_fifo_dedup_range_count_test.sv =====
module packet_fifo_dedup_range_count_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  localparam int Depth = 64;
  localparam int StallLimit = 20000;
  localparam int DirectedRows = 22;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_data_i = 7'd64;

  packet_fifo_dedup_range_count #(.CAPACITY(Depth)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] stamp;
  } packet_t;

  packet_t queue_mirror[$];
  logic [6:0] limit_shadow;
  out_word_t pending_results[$];

  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int adds_sent = 0;
  int fwds_sent = 0;
  int counts_sent = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  bit stimulus_done = 1'b0;

  in_word_t  dir_word[DirectedRows];
  out_word_t dir_result[DirectedRows];
  bit        dir_known[DirectedRows];

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    packet_t p;
    int lim;
    int cnt;
    bit dup;
    r = '0;
    p = '{w.src_id, w.dst_id, w.arrival_time};
    lim = limit_shadow;
    if (lim == 0) lim = 1;
    if (lim > Depth) lim = Depth;
    case (w.req_type)
      ReqAdd: begin
        dup = 1'b0;
        foreach (queue_mirror[i]) if (queue_mirror[i] == p) dup = 1'b1;
        if (!dup) begin
          if (queue_mirror.size() >= lim) void'(queue_mirror.pop_front());
          if (queue_mirror.size() < Depth) queue_mirror.insert(queue_mirror.size(), p);
          r.accepted = 1'b1;
        end
      end
      ReqFwd: begin
        if (queue_mirror.size() != 0) begin
          p = queue_mirror.pop_front();
          r.packet_valid = 1'b1;
          r.out_src = p.src;
          r.out_dst = p.dst;
          r.out_time = p.stamp;
        end
      end
      ReqCnt: begin
        cnt = 0;
        foreach (queue_mirror[i])
          if (queue_mirror[i].dst == w.dst_id && queue_mirror[i].stamp >= w.range_start &&
              queue_mirror[i].stamp <= w.range_end) cnt++;
        if (cnt > 127) cnt = 127;
        r.match_count = 7'(cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(in_word_t w, bit known, out_word_t want);
    out_word_t got;
    got = predict_word(w);
    if (known && got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with prediction: table %h predicted %h", want, got);
    end
    pending_results.insert(pending_results.size(), got);
    in_word_i <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    case (w.req_type)
      ReqAdd: adds_sent++;
      ReqFwd: fwds_sent++;
      ReqCnt: counts_sent++;
      default: ;
    endcase
    @(negedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_set_limit(logic [6:0] lim);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    cfg_data_i <= lim;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_shadow = lim;
  endtask

  function automatic in_word_t random_word(int pool);
    in_word_t w;
    packet_t p;
    int k;
    w.req_type = 2'($urandom_range(0, 99) < 45 ? ReqAdd :
                 ($urandom_range(0, 1) ? ReqFwd : ReqCnt));
    if ($urandom_range(0, 49) == 0) w.req_type = ReqNone;
    w.src_id = 16'($urandom_range(0, pool));
    w.dst_id = 16'($urandom_range(0, pool));
    w.arrival_time = 32'($urandom_range(0, pool * 4));
    w.range_start = 32'($urandom_range(0, pool * 4));
    w.range_end = 32'($urandom_range(0, pool * 4));
    if ($urandom_range(0, 9) == 0) begin
      w.src_id = 16'($urandom);
      w.dst_id = 16'($urandom);
      w.arrival_time = $urandom;
      w.range_start = $urandom;
      w.range_end = $urandom;
    end
    if (queue_mirror.size() != 0 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, queue_mirror.size() - 1);
      p = queue_mirror[k];
      w.src_id = p.src;
      w.dst_id = p.dst;
      w.arrival_time = p.stamp;
      if ($urandom_range(0, 1)) begin
        w.range_start = p.stamp - 32'($urandom_range(0, 3));
        w.range_end = p.stamp + 32'($urandom_range(0, 3));
      end
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    out_word_t none;
    logic [6:0] limits[8];
    limits = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd5, 7'd33, 7'd64};
    none = '0;
    for (int i = 0; i < DirectedRows; i++) begin
      dir_word[i] = '0;
      dir_result[i] = '0;
      dir_known[i] = 1'b0;
    end
    dir_word[0].req_type = ReqFwd; dir_known[0] = 1'b1;
    dir_word[1].req_type = ReqCnt; dir_word[1].range_end = '1; dir_known[1] = 1'b1;
    dir_word[2].req_type = ReqNone; dir_known[2] = 1'b1;
    dir_word[3] = '{ReqAdd, 16'hffff, 16'hffff, 32'hffffffff, 32'h0, 32'h0};
    dir_result[3].accepted = 1'b1; dir_known[3] = 1'b1;
    dir_word[4] = dir_word[3]; dir_known[4] = 1'b1;
    dir_word[5] = '{ReqAdd, 16'h0, 16'h0, 32'h0, 32'hffffffff, 32'hffffffff};
    dir_result[5].accepted = 1'b1; dir_known[5] = 1'b1;
    dir_word[6] = '{ReqAdd, 16'h1234, 16'hffff, 32'h10, 32'h0, 32'h0};
    dir_word[7] = '{ReqCnt, 16'h0, 16'hffff, 32'h0, 32'h0, 32'hffffffff};
    dir_word[8] = '{ReqCnt, 16'h0, 16'hffff, 32'h0, 32'hffffffff, 32'h0};
    dir_known[8] = 1'b1;
    dir_word[9] = '{ReqCnt, 16'h0, 16'hffff, 32'h0, 32'h10, 32'h10};
    dir_word[10] = '{ReqCnt, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0};
    dir_word[11] = '{ReqFwd, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0};
    dir_result[11] = '{1'b0, 1'b1, 16'hffff, 16'hffff, 32'hffffffff, 7'd0};
    dir_known[11] = 1'b1;
    dir_word[12] = '{ReqAdd, 16'haaaa, 16'h5555, 32'haaaa5555, 32'h0, 32'h0};
    dir_word[13] = '{ReqAdd, 16'h5555, 16'haaaa, 32'h5555aaaa, 32'h0, 32'h0};
    dir_word[14] = '{ReqNone, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    dir_known[14] = 1'b1;
    for (int i = 15; i < 19; i++) dir_word[i].req_type = ReqFwd;
    dir_word[19].req_type = ReqCnt;
    dir_word[20] = '{ReqAdd, 16'h1, 16'h2, 32'h3, 32'h0, 32'h0};
    dir_word[21] = '{ReqCnt, 16'h0, 16'h2, 32'h0, 32'h3, 32'h3};
    for (int i = 0; i < DirectedRows; i++)
      if (dir_word[i].req_type == ReqNone) dir_result[i] = none;

    limit_shadow = 7'd64;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DirectedRows; i++) send_word(dir_word[i], dir_known[i], dir_result[i]);

    foreach (limits[j]) begin
      drain_and_set_limit(limits[j]);
      for (int n = 0; n < 220; n++) begin
        w = random_word(limits[j] < 8 ? 6 : 40);
        send_word(w, 1'b0, none);
      end
      if (limits[j] == 7'd64)
        for (int n = 0; n < 70; n++) begin
          w = random_word(60000);
          w.req_type = ReqAdd;
          send_word(w, 1'b0, none);
        end
    end
    in_valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    forever begin
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      repeat ($urandom_range(0, 3)) begin
        out_stall_i <= $urandom_range(0, 1);
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word_o);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_word_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %h actual %h",
                     words_checked, want, out_word_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) timed_out = 1'b1;
  end

  initial begin
    wait (stimulus_done || timed_out);
    if (!timed_out) wait (pending_results.size() == 0 || timed_out);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d words (%0d add, %0d forward, %0d count) over 8 limit settings.",
             words_sent, adds_sent, fwds_sent, counts_sent);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (timed_out) begin
      $display("packet_fifo_dedup_range_count_test: errors");
    end else if (mismatches == 0 && pending_results.size() == 0) begin
      $display("packet_fifo_dedup_range_count_test: clean");
    end else begin
      $display("packet_fifo_dedup_range_count_test: errors");
    end
    $finish;
  end

endmodule
